[hdl/dmwbc_pkg.sv]
// Shared types, constants and codes for the direct-mapped write-back cache.
// No dependencies; every other file in hdl/ refers to this package by scope.
`timescale 1ns / 1ps

package dmwbc_pkg;

    // Fixed field widths of the request and response.
    localparam int ADDR_W     = 16;
    localparam int VALUE_W    = 8;
    localparam int OUT_DATA_W = 64;
    localparam int ADDR_SPAN  = 65536;

    // Default geometry, handed to the top-level parameters.
    localparam int LINE_COUNT_DEF   = 64;
    localparam int BLOCK_BYTES_DEF  = 8;
    localparam int MEMORY_BYTES_DEF = 65536;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        logic               func;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     read_address;
        logic [OUT_DATA_W-1:0] block_data;
        logic                  hit;
        logic                  was_dirty;
    } rsp_t;

    // Classified access as it sits in the queue.
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
    } acc_t;

    // Status of the front end, seen at the top level.
    typedef struct packed {
        logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
        logic                             full;
    } front_status_t;

    // Status of the back end, seen at the top level.
    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH,
        ST_FILL
    } back_state_t;

endpackage

[hdl/dmwbc_front.sv]
// Front end of the cache: accepts requests, classifies them and queues them.
// Depends on dmwbc_pkg.
`timescale 1ns / 1ps

module dmwbc_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  dmwbc_pkg::req_t         req,
    output logic                    q_valid,
    output dmwbc_pkg::acc_t         q_head,
    input  logic                    q_pop,
    output dmwbc_pkg::front_status_t status
);

    localparam int PTR_W = $clog2(dmwbc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dmwbc_pkg::QUEUE_DEPTH + 1);

    dmwbc_pkg::acc_t  slot_reg [dmwbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    dmwbc_pkg::acc_t  classified;

    // Decode the access kind and keep the fields the back end needs.
    always_comb
    begin
        classified.op      = req.func ? dmwbc_pkg::OP_WRITE : dmwbc_pkg::OP_READ;
        classified.address = req.address;
        classified.value   = req.write_value;
    end

    assign req_stall = (count_reg == CNT_W'(dmwbc_pkg::QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign q_head    = slot_reg[rd_ptr_reg];

    assign status.count = count_reg;
    assign status.full  = req_stall;

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(dmwbc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(dmwbc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[hdl/dmwbc_back.sv]
// Back end of the cache: line array, backing memory and the access sequencer.
// Depends on dmwbc_pkg; fed by dmwbc_front through its queue.
`timescale 1ns / 1ps

module dmwbc_back
#(
    parameter int LINE_COUNT   = dmwbc_pkg::LINE_COUNT_DEF,
    parameter int BLOCK_BYTES  = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  dmwbc_pkg::acc_t         q_head,
    output logic                    q_pop,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output dmwbc_pkg::rsp_t         rsp,
    output dmwbc_pkg::back_status_t status
);

    localparam int ADDR_W    = dmwbc_pkg::ADDR_W;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int LINE_W    = $clog2(LINE_COUNT);
    localparam int TAG_RAW   = ADDR_W - OFF_W - LINE_W;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int DATA_W    = 8 * BLOCK_BYTES;
    localparam int MEM_SPAN  = (MEMORY_BYTES < dmwbc_pkg::ADDR_SPAN) ? MEMORY_BYTES
                             : dmwbc_pkg::ADDR_SPAN;
    localparam int MEM_WORDS = MEM_SPAN / BLOCK_BYTES;
    localparam int MW_W      = $clog2(MEM_WORDS);
    localparam int CLR_N     = (MEM_WORDS > LINE_COUNT) ? MEM_WORDS : LINE_COUNT;
    localparam int CLR_W     = $clog2(CLR_N);

    typedef struct packed {
        logic              dirty;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] data;
    } line_t;

    // Storage arrays.
    line_t             line_mem [LINE_COUNT];
    logic [DATA_W-1:0] back_mem [MEM_WORDS];

    dmwbc_pkg::back_state_t state_reg, state_next;
    dmwbc_pkg::acc_t        cur_reg;
    line_t                  line_rd_reg;
    logic [DATA_W-1:0]      mem_rd_reg;
    logic [CLR_W-1:0]       clr_reg;
    dmwbc_pkg::rsp_t        out_reg;
    logic                   out_valid_reg, out_valid_next;

    logic              line_rd_en;
    logic [LINE_W-1:0] line_rd_idx;
    logic              line_wr_en;
    logic [LINE_W-1:0] line_wr_idx;
    line_t             line_wr_data;
    logic              mem_wr_en;
    logic [MW_W-1:0]   mem_wr_idx;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [MW_W-1:0]   mem_rd_idx;
    logic              out_load;
    logic              out_hit;
    logic [DATA_W-1:0] out_block;

    logic                  is_write;
    logic [LINE_W-1:0]     cur_line;
    logic [TAG_W-1:0]      cur_tag;
    logic [OFF_W-1:0]      cur_off;
    logic                  tag_match;
    logic                  out_free;
    logic                  finish_ok;
    logic [DATA_W-1:0]     merge_base;
    logic [DATA_W-1:0]     merged;
    logic [DATA_W+63:0]    block_ext;
    logic [CLR_W:0]        clr_wide;

    // Split the current address into offset, line and tag.
    assign is_write  = (cur_reg.op == dmwbc_pkg::OP_WRITE);
    assign cur_off   = cur_reg.address[OFF_W-1:0];
    assign cur_line  = cur_reg.address[OFF_W +: LINE_W];
    assign cur_tag   = TAG_W'(cur_reg.address >> (OFF_W + LINE_W));
    assign tag_match = (line_rd_reg.tag == cur_tag);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign clr_wide  = {1'b0, clr_reg};

    // An access may finish when it is a write or the response register is free.
    assign finish_ok = is_write || out_free;

    // Insert the written byte into the block.
    assign merge_base = (state_reg == dmwbc_pkg::ST_FILL) ? mem_rd_reg : line_rd_reg.data;
    always_comb
    begin
        merged = merge_base;
        merged[{cur_off, 3'b000} +: 8] = cur_reg.value;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = dmwbc_pkg::ST_LOOKUP;
                end
            end
            dmwbc_pkg::ST_LOOKUP:
            begin
                if (!tag_match)
                begin
                    state_next = dmwbc_pkg::ST_FETCH;
                end
                else if (finish_ok)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_FETCH:
            begin
                state_next = dmwbc_pkg::ST_FILL;
            end
            dmwbc_pkg::ST_FILL:
            begin
                if (finish_ok)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and memory-control logic.
    always_comb
    begin
        q_pop        = 1'b0;
        line_rd_en   = 1'b0;
        line_rd_idx  = q_head.address[OFF_W +: LINE_W];
        line_wr_en   = 1'b0;
        line_wr_idx  = cur_line;
        line_wr_data = '0;
        mem_wr_en    = 1'b0;
        mem_wr_idx   = MW_W'({line_rd_reg.tag, cur_line});
        mem_wr_data  = line_rd_reg.data;
        mem_rd_en    = 1'b0;
        mem_rd_idx   = MW_W'(cur_reg.address >> OFF_W);
        out_load     = 1'b0;
        out_hit      = 1'b0;
        out_block    = line_rd_reg.data;
        case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                line_wr_idx = clr_reg[LINE_W-1:0];
                line_wr_en  = (clr_wide < (CLR_W+1)'(LINE_COUNT));
                mem_wr_idx  = clr_reg[MW_W-1:0];
                mem_wr_data = '0;
                mem_wr_en   = (clr_wide < (CLR_W+1)'(MEM_WORDS));
            end
            dmwbc_pkg::ST_IDLE:
            begin
                q_pop      = q_valid;
                line_rd_en = q_valid;
            end
            dmwbc_pkg::ST_LOOKUP:
            begin
                if (tag_match)
                begin
                    if (finish_ok)
                    begin
                        line_wr_en         = is_write;
                        line_wr_data.dirty = 1'b1;
                        line_wr_data.tag   = cur_tag;
                        line_wr_data.data  = merged;
                        out_load           = !is_write;
                        out_hit            = 1'b1;
                    end
                end
                else
                begin
                    // Write back a dirty victim before the refill read.
                    mem_wr_en = line_rd_reg.dirty;
                end
            end
            dmwbc_pkg::ST_FETCH:
            begin
                mem_rd_en = 1'b1;
            end
            dmwbc_pkg::ST_FILL:
            begin
                out_block = mem_rd_reg;
                if (finish_ok)
                begin
                    line_wr_en         = 1'b1;
                    line_wr_data.dirty = is_write;
                    line_wr_data.tag   = cur_tag;
                    line_wr_data.data  = is_write ? merged : mem_rd_reg;
                    out_load           = !is_write;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign block_ext      = {64'd0, out_block};
    assign out_valid_next = out_load ? 1'b1 : (rsp_stall ? out_valid_reg : 1'b0);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmwbc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == dmwbc_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (out_load)
        begin
            out_reg.read_address <= cur_reg.address;
            out_reg.block_data   <= block_ext[63:0];
            out_reg.hit          <= out_hit;
            out_reg.was_dirty    <= line_rd_reg.dirty;
        end
    end

    // Line array: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (line_wr_en)
        begin
            line_mem[line_wr_idx] <= line_wr_data;
        end
        if (line_rd_en)
        begin
            line_rd_reg <= line_mem[line_rd_idx];
        end
    end

    // Backing memory: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            back_mem[mem_wr_idx] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rd_reg <= back_mem[mem_rd_idx];
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp             = out_reg;
    assign status.clearing = (state_reg == dmwbc_pkg::ST_CLEAR);
    assign status.busy     = (state_reg != dmwbc_pkg::ST_IDLE);

endmodule

[hdl/direct_mapped_writeback_cache.sv]
// Top level of the direct-mapped write-back write-allocate cache.
// Depends on dmwbc_pkg, dmwbc_front and dmwbc_back.
//
//   Channel | Direction | Handshake        | Payload
//   --------+-----------+------------------+---------------------------
//   req     | in        | req_valid / stall| func, address, write_value
//   rsp     | out       | rsp_valid / stall| read_address, block_data,
//           |           |                  | hit, was_dirty (reads only)
//
// A hit passes through the back end as line array read, then compare/update.
// A miss goes through victim write-back, backing read, then line refill.
// After reset a clearing pass over max(memory words, lines) entries (8192 by
// default) zeroes both arrays; requests only queue up meanwhile.
// A two-entry queue decouples intake from the back end; a stalled response
// holds the back end only when a read is ready to finish.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache
#(
    parameter int LINE_COUNT   = dmwbc_pkg::LINE_COUNT_DEF,
    parameter int BLOCK_BYTES  = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dmwbc_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dmwbc_pkg::rsp_t rsp
);

    logic                     q_valid;
    logic                     q_pop;
    dmwbc_pkg::acc_t          q_head;
    dmwbc_pkg::front_status_t front_status;
    dmwbc_pkg::back_status_t  back_status;

    // Intake and classification.
    dmwbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .status    (front_status)
    );

    // Lookup, write-back and refill.
    dmwbc_back
    #(
        .LINE_COUNT   (LINE_COUNT),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .MEMORY_BYTES (MEMORY_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .status    (back_status)
    );

`ifndef SYNTH
    // The back end only takes from a non-empty queue.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Nothing leaves the queue during the clearing pass.
    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> !q_pop)
        else $error("queue popped during clearing pass");

    // A response never appears while the arrays are still being cleared.
    a_no_rsp_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(back_status.clearing))
        else $error("response produced during clearing pass");

    // A full queue with an idle back end is popped in the same cycle.
    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (front_status.full && !back_status.busy) |-> q_pop)
        else $error("idle back end left a full queue");
`endif

endmodule

[tb/tb_direct_mapped_writeback_cache.sv]
// Self-checking testbench for the direct-mapped write-back write-allocate cache.
// Depends on dmwbc_pkg and direct_mapped_writeback_cache; needs no other files.
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache;

    localparam int LINES      = 64;
    localparam int MEM_WORDS  = 8192;
    localparam int END_CYCLES = 50;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    dmwbc_pkg::req_t req;
    logic            rsp_valid;
    logic            rsp_stall;
    dmwbc_pkg::rsp_t rsp;

    // Mirror of the cache state used to predict read responses.
    logic [6:0]  mirror_tag [LINES];
    logic [63:0] mirror_line [LINES];
    logic        mirror_dirty [LINES];
    logic [63:0] mirror_mem [MEM_WORDS];

    dmwbc_pkg::rsp_t pending_reads[$];
    int              error_count;
    int              rsp_wait;

    direct_mapped_writeback_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one access to the mirror and queue the expected read response.
    task automatic predict_access(input dmwbc_pkg::req_t item);
        logic [2:0]      offset;
        logic [5:0]      line;
        logic [6:0]      tag;
        logic            dirty_before;
        logic            tag_match;
        dmwbc_pkg::rsp_t expected;
        offset       = item.address[2:0];
        line         = item.address[8:3];
        tag          = item.address[15:9];
        dirty_before = mirror_dirty[line];
        tag_match    = (mirror_tag[line] == tag);
        if (!tag_match)
        begin
            if (mirror_dirty[line])
            begin
                mirror_mem[{mirror_tag[line], line}] = mirror_line[line];
                mirror_dirty[line] = 1'b0;
            end
            mirror_line[line] = mirror_mem[item.address[15:3]];
            mirror_tag[line]  = tag;
        end
        if (dmwbc_pkg::op_t'(item.func) == dmwbc_pkg::OP_WRITE)
        begin
            mirror_line[line][offset*8 +: 8] = item.write_value;
            mirror_dirty[line] = 1'b1;
        end
        else
        begin
            expected.read_address = item.address;
            expected.block_data   = mirror_line[line];
            expected.hit          = tag_match;
            expected.was_dirty    = dirty_before;
            pending_reads.push_back(expected);
        end
    endtask

    // Send one request after a random gap and wait until it is accepted.
    // Valid stays high into the next request when there is no gap.
    task automatic send_access(input dmwbc_pkg::op_t op, input logic [15:0] addr,
                               input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.func        <= op;
        req.address     <= addr;
        req.write_value <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_access(req);
    endtask

    // Stop sending and wait until every expected response has come.
    task automatic drain_reads();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
    endtask

    // Directed: tag 0 hits from reset, field extremes, write-back and wrap.
    task automatic test_directed();
        send_access(dmwbc_pkg::OP_READ, 16'h0000, 8'h00);
        send_access(dmwbc_pkg::OP_READ, 16'h01FF, 8'hFF);
        send_access(dmwbc_pkg::OP_WRITE, 16'h0000, 8'hFF);
        send_access(dmwbc_pkg::OP_WRITE, 16'h0007, 8'h80);
        send_access(dmwbc_pkg::OP_READ, 16'h0003, 8'h55);
        send_access(dmwbc_pkg::OP_READ, 16'hFE00, 8'h00);
        send_access(dmwbc_pkg::OP_READ, 16'h0000, 8'h00);
        send_access(dmwbc_pkg::OP_WRITE, 16'hFFFF, 8'hA5);
        send_access(dmwbc_pkg::OP_WRITE, 16'hFFF8, 8'h5A);
        send_access(dmwbc_pkg::OP_READ, 16'h01F8, 8'h00);
        send_access(dmwbc_pkg::OP_READ, 16'hFFFC, 8'h00);
        send_access(dmwbc_pkg::OP_WRITE, 16'h5555, 8'h01);
        send_access(dmwbc_pkg::OP_WRITE, 16'hAAAA, 8'hFE);
        send_access(dmwbc_pkg::OP_READ, 16'h5550, 8'h00);
        send_access(dmwbc_pkg::OP_READ, 16'hAAAA, 8'h00);
        send_access(dmwbc_pkg::OP_READ, 16'h8000, 8'h00);
        drain_reads();
    endtask

    // Random: addresses confined to a few tags so hits, misses and
    // dirty evictions all occur often; a share roams the whole space.
    task automatic test_random(input int count);
        logic [15:0] addr;
        logic [6:0]  tag;
        for (int n = 0; n < count; n++)
        begin
            tag  = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 3));
            addr = {tag, 6'($urandom_range(0, 7)), 3'($urandom)};
            if ($urandom_range(0, 4) == 0)
                addr = 16'($urandom);
            send_access(dmwbc_pkg::op_t'($urandom_range(0, 1)), addr, 8'($urandom));
            if (n == count / 2)
                drain_reads();
        end
    endtask

    // Response stall driver: each response waits a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_wait = 0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                rsp_wait = $urandom_range(0, 15);
            else if (rsp_valid && rsp_wait > 0)
                rsp_wait = rsp_wait - 1;
            rsp_stall <= (rsp_wait != 0);
        end
    end

    // Response checker.
    always @(posedge clk)
    begin
        dmwbc_pkg::rsp_t expected;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("response with no read outstanding, address %h", rsp.read_address);
                error_count++;
            end
            else
            begin
                expected = pending_reads.pop_front();
                if (rsp.read_address !== expected.read_address)
                begin
                    $error("read_address: expected %h, actual %h",
                           expected.read_address, rsp.read_address);
                    error_count++;
                end
                if (rsp.block_data !== expected.block_data)
                begin
                    $error("block_data: expected %h, actual %h",
                           expected.block_data, rsp.block_data);
                    error_count++;
                end
                if (rsp.hit !== expected.hit)
                begin
                    $error("hit: expected %b, actual %b", expected.hit, rsp.hit);
                    error_count++;
                end
                if (rsp.was_dirty !== expected.was_dirty)
                begin
                    $error("was_dirty: expected %b, actual %b",
                           expected.was_dirty, rsp.was_dirty);
                    error_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        error_count = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        for (int i = 0; i < LINES; i++)
        begin
            mirror_tag[i]   = '0;
            mirror_line[i]  = '0;
            mirror_dirty[i] = 1'b0;
        end
        for (int i = 0; i < MEM_WORDS; i++)
            mirror_mem[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(1830);
        drain_reads();
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_reads.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/dmwbc_pkg.sv
hdl/dmwbc_front.sv
hdl/dmwbc_back.sv
hdl/direct_mapped_writeback_cache.sv
tb/tb_direct_mapped_writeback_cache.sv
